>>> rtl/core/abss_pkg.sv
// ----------------------------------------------------------------------------
// abss_pkg: shared types and constants for the beam sweep selector
// Widths, command and mode codes, register map and compare unit opcodes.
// ----------------------------------------------------------------------------
package abss_pkg;

  localparam int unsigned NUM_POSITIONS_DEF = 12;

  localparam int unsigned RSSI_W = 8;
  localparam int unsigned POS_W  = 4;
  localparam int unsigned DROP_W = 7;
  localparam int unsigned CMP_W  = 10;   // holds hold_reference - hold_drop_db
  localparam int unsigned PADDR_W = 3;

  localparam logic signed [RSSI_W-1:0] RSSI_FLOOR = 8'sh80;
  localparam logic [DROP_W-1:0]        DROP_RESET = 7'd6;

  // command_kind codes
  localparam logic CMD_ROTATE = 1'b0;
  localparam logic CMD_HOLD   = 1'b1;

  // mode codes
  localparam logic MODE_SWEEP = 1'b0;
  localparam logic MODE_HOLD  = 1'b1;

  // register index (paddr[2])
  localparam logic [0:0] REG_HOLD_DROP = 1'b0;

  typedef enum logic [1:0] {
    OP_SCAN   = 2'd0,   // new sample vs running scan max
    OP_SEARCH = 2'd1,   // stored entry vs best so far
    OP_DROP   = 2'd2    // (hold ref - drop) vs scan best
  } cmp_op_e;

  typedef struct packed {
    logic                     kind;
    logic [POS_W-1:0]         target;
    logic signed [RSSI_W-1:0] best;
    logic                     mode;
    logic                     last;
  } out_t;

endpackage

>>> rtl/core/abss_in_if.sv
// ----------------------------------------------------------------------------
// abss_in_if: scan sample channel
// One transaction carries one heard device or an empty-scan marker.
// ----------------------------------------------------------------------------
interface abss_in_if;
  logic              valid;
  logic              ready;
  logic signed [7:0] rssi_dbm;
  logic              device_present;
  logic              last_of_scan;

  modport source (output valid, output rssi_dbm, output device_present,
                  output last_of_scan, input ready);
  modport sink   (input valid, input rssi_dbm, input device_present,
                  input last_of_scan, output ready);
endinterface

>>> rtl/core/abss_out_if.sv
// ----------------------------------------------------------------------------
// abss_out_if: beam command channel
// One transaction carries one rotate or hold command.
// ----------------------------------------------------------------------------
interface abss_out_if;
  logic              valid;
  logic              ready;
  logic              command_kind;
  logic [3:0]        target_position;
  logic signed [7:0] scan_best_dbm;
  logic              mode_after;
  logic              last_result;

  modport source (output valid, output command_kind, output target_position,
                  output scan_best_dbm, output mode_after, output last_result,
                  input ready);
  modport sink   (input valid, input command_kind, input target_position,
                  input scan_best_dbm, input mode_after, input last_result,
                  output ready);
endinterface

>>> rtl/core/antenna_beam_sweep_select.sv
// ----------------------------------------------------------------------------
// antenna_beam_sweep_select: switched-beam position selector
// Tracks per-scan signal peaks, sweeps beam positions and holds the best.
// ----------------------------------------------------------------------------
// Usage:
//   in_i  : one transaction per heard device (or empty marker), last_of_scan
//           flags the end of a scan. Ready only while the sequencer is idle.
//   out_o : rotate/hold commands, one or two per completed scan.
//   APB   : hold_drop_db at address 0; write it only while idle; not enforced.
// Sequence:
//   Item inside a scan: taken while idle, next item the cycle after.
//   End of scan: evaluated in S_EVAL, then the command is presented in
//   S_OUT; no new item is taken until the receiver takes the command.
//   End of sweep: the stored peaks are walked one entry per cycle through
//   the shared compare unit in S_SEARCH, then rotate and hold are presented
//   back to back in S_OUT.
// Reset: sweep mode, position 1, drop 6, peak store unwritten.
// Stall: a command stays on out_o until taken; no new item is taken then.
// ----------------------------------------------------------------------------
module antenna_beam_sweep_select #(
  parameter int unsigned NumPositions = abss_pkg::NUM_POSITIONS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  abss_in_if.sink                       in_i,
  abss_out_if.source                    out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [abss_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import abss_pkg::*;

  localparam int unsigned IdxW = $clog2(NumPositions);
  localparam int unsigned CntW = $clog2(NumPositions + 1);
  localparam logic [POS_W-1:0] LastPos = POS_W'(NumPositions);
  localparam logic [CntW-1:0]  CntEnd  = CntW'(NumPositions);
  localparam logic [IdxW-1:0]  LastIdx = IdxW'(NumPositions - 1);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_EVAL   = 4'b0010,
    S_SEARCH = 4'b0100,
    S_OUT    = 4'b1000
  } state_e;

  state_e                   state_q, state_d;
  logic                     mode_q, mode_d;
  logic [POS_W-1:0]         beam_q, beam_d;
  logic signed [RSSI_W-1:0] scan_max_q, scan_max_d;
  logic signed [RSSI_W-1:0] href_q, href_d;
  logic [DROP_W-1:0]        drop_q;
  logic                     pend_q, pend_d;
  logic [CntW-1:0]          cnt_q, cnt_d;
  logic                     rd_vld_q, rd_vld_d;

  logic signed [RSSI_W-1:0] best_q, best_d;
  logic signed [RSSI_W-1:0] rd_q;
  logic [IdxW-1:0]          rd_idx_q;
  logic signed [RSSI_W-1:0] top_q, top_d;
  logic [IdxW-1:0]          sel_q, sel_d;
  out_t                     out_q, out_d;

  logic signed [RSSI_W-1:0] mem [NumPositions];
  logic                     mem_we;
  logic [IdxW-1:0]          mem_waddr;
  logic                     rd_en;

  logic                     in_acc, out_acc, cfg_we, cfg_hit;
  logic                     cmp_gt, take;
  cmp_op_e                  cmp_op;
  logic signed [RSSI_W-1:0] scan_cur;

  // handshakes
  assign in_i.ready  = (state_q == S_IDLE);
  assign in_acc      = in_i.valid & in_i.ready;
  assign out_o.valid = (state_q == S_OUT);
  assign out_acc     = out_o.valid & out_o.ready;

  assign out_o.command_kind    = out_q.kind;
  assign out_o.target_position = out_q.target;
  assign out_o.scan_best_dbm   = out_q.best;
  assign out_o.mode_after      = out_q.mode;
  assign out_o.last_result     = out_q.last;

  // config port
  assign cfg_hit = (paddr[PADDR_W-1:2] == REG_HOLD_DROP);
  assign cfg_we  = psel & penable & pwrite & cfg_hit;
  assign pready  = 1'b1;
  assign prdata  = cfg_hit ? {{(32-DROP_W){1'b0}}, drop_q} : 32'd0;

  // shared compare unit
  always_comb begin
    unique case (state_q)
      S_EVAL:   cmp_op = OP_DROP;
      S_SEARCH: cmp_op = OP_SEARCH;
      default:  cmp_op = OP_SCAN;
    endcase
  end

  abss_cmp u_cmp (
    .op_i       (cmp_op),
    .rssi_i     (in_i.rssi_dbm),
    .scan_max_i (scan_max_q),
    .entry_i    (rd_q),
    .top_i      (top_q),
    .hold_ref_i (href_q),
    .drop_i     (drop_q),
    .best_i     (best_q),
    .gt_o       (cmp_gt)
  );

  // first entry always seeds the search; later ones must be strictly larger
  assign take     = (rd_idx_q == '0) | cmp_gt;
  assign scan_cur = (in_i.device_present && cmp_gt) ? in_i.rssi_dbm : scan_max_q;
  assign rd_en    = (state_q == S_SEARCH) && (cnt_q != CntEnd);

  always_comb begin
    state_d    = state_q;
    mode_d     = mode_q;
    beam_d     = beam_q;
    scan_max_d = scan_max_q;
    href_d     = href_q;
    pend_d     = pend_q;
    cnt_d      = cnt_q;
    rd_vld_d   = 1'b0;
    best_d     = best_q;
    top_d      = top_q;
    sel_d      = sel_q;
    out_d      = out_q;
    mem_we     = 1'b0;
    mem_waddr  = IdxW'(beam_q - POS_W'(1));

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (in_i.last_of_scan) begin
            best_d     = scan_cur;
            scan_max_d = RSSI_FLOOR;
            state_d    = S_EVAL;
          end else begin
            scan_max_d = scan_cur;
          end
        end
      end
      S_EVAL: begin
        out_d.best = best_q;
        out_d.last = 1'b1;
        if (mode_q == MODE_SWEEP) begin
          mem_we = 1'b1;
          if (beam_q < LastPos) begin
            beam_d       = beam_q + POS_W'(1);
            out_d.kind   = CMD_ROTATE;
            out_d.target = beam_q + POS_W'(1);
            out_d.mode   = MODE_SWEEP;
            state_d      = S_OUT;
          end else begin
            cnt_d   = '0;
            state_d = S_SEARCH;
          end
        end else if (cmp_gt) begin
          // fell more than the drop below the reference: restart the sweep at position 1
          beam_d       = POS_W'(1);
          mode_d       = MODE_SWEEP;
          out_d.kind   = CMD_ROTATE;
          out_d.target = POS_W'(1);
          out_d.mode   = MODE_SWEEP;
          state_d      = S_OUT;
        end else begin
          out_d.kind   = CMD_HOLD;
          out_d.target = beam_q;
          out_d.mode   = MODE_HOLD;
          state_d      = S_OUT;
        end
      end
      S_SEARCH: begin
        if (rd_en) begin
          rd_vld_d = 1'b1;
          cnt_d    = cnt_q + CntW'(1);
        end
        if (rd_vld_q && take) begin
          top_d = rd_q;
          sel_d = rd_idx_q;
        end
        if (rd_vld_q && (rd_idx_q == LastIdx)) begin
          beam_d       = POS_W'(sel_d) + POS_W'(1);
          href_d       = top_d;
          mode_d       = MODE_HOLD;
          pend_d       = 1'b1;
          out_d.kind   = CMD_ROTATE;
          out_d.target = POS_W'(sel_d) + POS_W'(1);
          out_d.best   = best_q;
          out_d.mode   = MODE_HOLD;
          out_d.last   = 1'b0;
          state_d      = S_OUT;
        end
      end
      S_OUT: begin
        if (out_acc) begin
          if (pend_q) begin
            pend_d       = 1'b0;
            out_d.kind   = CMD_HOLD;
            out_d.target = beam_q;
            out_d.mode   = MODE_HOLD;
            out_d.last   = 1'b1;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      mode_q     <= MODE_SWEEP;
      beam_q     <= POS_W'(1);
      scan_max_q <= RSSI_FLOOR;
      href_q     <= RSSI_FLOOR;
      drop_q     <= DROP_RESET;
      pend_q     <= 1'b0;
      cnt_q      <= '0;
      rd_vld_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      mode_q     <= mode_d;
      beam_q     <= beam_d;
      scan_max_q <= scan_max_d;
      href_q     <= href_d;
      pend_q     <= pend_d;
      cnt_q      <= cnt_d;
      rd_vld_q   <= rd_vld_d;
      if (cfg_we) begin
        drop_q <= pwdata[DROP_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    best_q <= best_d;
    top_q  <= top_d;
    sel_q  <= sel_d;
    out_q  <= out_d;
  end

  // peak store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= best_q;
    end
    if (rd_en) begin
      rd_q     <= mem[cnt_q[IdxW-1:0]];
      rd_idx_q <= cnt_q[IdxW-1:0];
    end
  end

endmodule

>>> rtl/core/abss_cmp.sv
// ----------------------------------------------------------------------------
// abss_cmp: shared signed compare unit
// Selects operands by opcode, forms the drop threshold, and compares a > b.
// ----------------------------------------------------------------------------
module abss_cmp (
  input  abss_pkg::cmp_op_e                     op_i,
  input  logic signed [abss_pkg::RSSI_W-1:0]    rssi_i,
  input  logic signed [abss_pkg::RSSI_W-1:0]    scan_max_i,
  input  logic signed [abss_pkg::RSSI_W-1:0]    entry_i,
  input  logic signed [abss_pkg::RSSI_W-1:0]    top_i,
  input  logic signed [abss_pkg::RSSI_W-1:0]    hold_ref_i,
  input  logic        [abss_pkg::DROP_W-1:0]    drop_i,
  input  logic signed [abss_pkg::RSSI_W-1:0]    best_i,
  output logic                                  gt_o
);
  import abss_pkg::*;

  logic signed [CMP_W-1:0] opa, opb;

  function automatic logic signed [CMP_W-1:0] sx(input logic signed [RSSI_W-1:0] v);
    sx = {{(CMP_W-RSSI_W){v[RSSI_W-1]}}, v};
  endfunction

  always_comb begin
    unique case (op_i)
      OP_SCAN: begin
        opa = sx(rssi_i);
        opb = sx(scan_max_i);
      end
      OP_SEARCH: begin
        opa = sx(entry_i);
        opb = sx(top_i);
      end
      OP_DROP: begin
        opa = sx(hold_ref_i) - $signed({{(CMP_W-DROP_W){1'b0}}, drop_i});
        opb = sx(best_i);
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  assign gt_o = (opa > opb);

endmodule

>>> rtl/core/abss_chk.sv
// ----------------------------------------------------------------------------
// abss_chk: port-level checks for the beam sweep selector
// Watches the channel ports over time; bound to the top level below.
// ----------------------------------------------------------------------------
module abss_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic       out_kind_i,
  input logic [3:0] out_target_i,
  input logic       out_mode_i,
  input logic       out_last_i
);
  import abss_pkg::*;

  // no new sample is taken while a command is pending
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !in_ready_i)
    else $error("input ready while a command is pending");

  // first of two commands closes a sweep: rotate into hold mode
  a_first_of_two: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_last_i) |-> (out_kind_i == CMD_ROTATE && out_mode_i == MODE_HOLD))
    else $error("non-final command is not a rotate into hold");

  // the hold command follows the sweep-end rotate immediately
  a_hold_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_ready_i && !out_last_i) |=>
      (out_valid_i && out_kind_i == CMD_HOLD && out_last_i))
    else $error("hold command missing after sweep-end rotate");

  // positions are numbered from 1
  a_target_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_target_i != 4'd0))
    else $error("command targets position 0");

  // protocol: a stalled command stays valid
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i)
    else $error("command dropped while stalled");

endmodule

bind antenna_beam_sweep_select abss_chk u_abss_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_kind_i   (out_o.command_kind),
  .out_target_i (out_o.target_position),
  .out_mode_i   (out_o.mode_after),
  .out_last_i   (out_o.last_result)
);

>>> dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for the beam sweep selector
// Feeds scans of signal-strength samples, predicts each rotate/hold command
// in a behavioral model of the block or takes it from the directed table
// that opens the run, and checks it field by field. Random scans follow in
// phases with different drop settings and different sender/receiver idling.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import abss_pkg::*;

  localparam int NUM_POS      = NUM_POSITIONS_DEF;
  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 104;
  localparam logic [0:0] REG_UNUSED = 1'b1;  // no register at this index

  typedef struct {
    logic signed [7:0] rssi;
    logic              present;
    logic              eos;
    bit                typed;
    out_t              cmd;
  } scan_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  abss_in_if  sample_if ();
  abss_out_if cmd_if ();

  antenna_beam_sweep_select #(
    .NumPositions(NUM_POS)
  ) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (sample_if),
    .out_o  (cmd_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always #5ns clk_i = ~clk_i;

  // behavioral copy of the selector
  logic              model_mode;
  logic [3:0]        model_pos;
  logic signed [7:0] model_scan_max;
  logic signed [7:0] model_hold_ref;
  logic signed [7:0] model_strength [NUM_POS];
  logic [6:0]        model_drop;

  out_t      step_cmds[$];      // commands caused by the latest sample
  out_t      expected_cmds[$];  // commands not yet seen on cmd_if
  scan_row_t directed_rows[$];
  int        n_errors = 0;
  int        src_idle_pct = 0;
  int        snk_stall_pct = 0;

  task automatic flag_error(input string msg);
    n_errors++;
    if (n_errors <= 10) begin
      $display("%s", msg);
    end
  endtask

  function automatic void step_beam_model(input logic signed [7:0] rssi,
                                          input logic present, input logic eos);
    logic signed [7:0] best;
    logic signed [7:0] top;
    int                sel;
    step_cmds.delete();
    if (present && rssi > model_scan_max) model_scan_max = rssi;
    if (!eos) return;
    best = model_scan_max;
    model_scan_max = RSSI_FLOOR;
    if (model_mode == MODE_SWEEP) begin
      model_strength[model_pos - 1] = best;
      if (model_pos < NUM_POS) begin
        model_pos = model_pos + 4'd1;
        step_cmds.push_back({CMD_ROTATE, model_pos, best, MODE_SWEEP, 1'b1});
      end else begin
        // first position with the strongest peak wins
        sel = 0;
        top = model_strength[0];
        for (int i = 1; i < NUM_POS; i++) begin
          if (model_strength[i] > top) begin
            top = model_strength[i];
            sel = i;
          end
        end
        model_pos = 4'(sel + 1);
        model_hold_ref = top;
        model_mode = MODE_HOLD;
        step_cmds.push_back({CMD_ROTATE, model_pos, best, MODE_HOLD, 1'b0});
        step_cmds.push_back({CMD_HOLD, model_pos, best, MODE_HOLD, 1'b1});
      end
    end else if (int'(best) < int'(model_hold_ref) - int'(model_drop)) begin
      model_pos = 4'd1;
      model_mode = MODE_SWEEP;
      step_cmds.push_back({CMD_ROTATE, model_pos, best, MODE_SWEEP, 1'b1});
    end else begin
      step_cmds.push_back({CMD_HOLD, model_pos, best, MODE_HOLD, 1'b1});
    end
  endfunction

  function automatic logic signed [7:0] sat8(input int v);
    if (v > 127) return 8'sd127;
    if (v < -128) return RSSI_FLOOR;
    return 8'(v);
  endfunction

  function automatic void add_row(input logic signed [7:0] rssi, input logic present,
                                  input logic eos, input bit typed, input logic kind,
                                  input logic [3:0] tgt, input logic signed [7:0] best,
                                  input logic md);
    scan_row_t r;
    r.rssi = rssi;
    r.present = present;
    r.eos = eos;
    r.typed = typed;
    r.cmd = {kind, tgt, best, md, 1'b1};
    directed_rows.push_back(r);
  endfunction

  // Drive one sample, wait for its transaction, then book its commands.
  task automatic apply_sample(input logic signed [7:0] rssi, input logic present,
                              input logic eos, input bit typed, input out_t typed_cmd);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      sample_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    sample_if.valid          <= 1'b1;
    sample_if.rssi_dbm       <= rssi;
    sample_if.device_present <= present;
    sample_if.last_of_scan   <= eos;
    do @(posedge clk_i); while (!sample_if.ready);
    step_beam_model(rssi, present, eos);
    if (typed) begin
      expected_cmds.push_back(typed_cmd);
    end else begin
      foreach (step_cmds[i]) expected_cmds.push_back(step_cmds[i]);
    end
  endtask

  task automatic apb_write(input logic [0:0] idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apb_check_drop();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {REG_HOLD_DROP, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== {25'd0, model_drop}) begin
      flag_error($sformatf("hold_drop_db readback: want %0d got %0d", model_drop, prdata));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic check_cmd();
    out_t got;
    out_t want;
    got = {cmd_if.command_kind, cmd_if.target_position, cmd_if.scan_best_dbm,
           cmd_if.mode_after, cmd_if.last_result};
    if (expected_cmds.size() == 0) begin
      flag_error($sformatf("unexpected command: kind=%0d pos=%0d best=%0d mode=%0d last=%0d",
                           got.kind, got.target, got.best, got.mode, got.last));
      return;
    end
    want = expected_cmds.pop_front();
    if (got.kind !== want.kind || got.target !== want.target || got.best !== want.best ||
        got.mode !== want.mode || got.last !== want.last) begin
      flag_error($sformatf({"command mismatch: want kind=%0d pos=%0d best=%0d mode=%0d",
                            " last=%0d, got kind=%0d pos=%0d best=%0d mode=%0d last=%0d"},
                           want.kind, want.target, want.best, want.mode, want.last,
                           got.kind, got.target, got.best, got.mode, got.last));
    end
  endtask

  // command receiver
  initial begin : cmd_sink
    cmd_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && cmd_if.valid && cmd_if.ready) check_cmd();
      cmd_if.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
    end
  end

  initial begin : watchdog
    #5ms;
    $display("tb_top failed");
    $finish;
  end

  initial begin : stimulus
    logic [31:0]       wdata;
    logic signed [7:0] rssi;
    logic              present;
    int                sent;
    int                len;
    int                pick;
    bit                blank;

    rst_ni                   <= 1'b0;
    sample_if.valid          <= 1'b0;
    sample_if.rssi_dbm       <= '0;
    sample_if.device_present <= 1'b0;
    sample_if.last_of_scan   <= 1'b0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;

    model_mode     = MODE_SWEEP;
    model_pos      = 4'd1;
    model_scan_max = RSSI_FLOOR;
    model_hold_ref = RSSI_FLOOR;
    model_drop     = DROP_RESET;

    // first sweep: extremes, empty scans, a tie for the strongest position
    add_row(8'sd127,    1'b1, 1'b1, 1, CMD_ROTATE, 4'd2, 8'sd127,    MODE_SWEEP);
    add_row(8'sd5,      1'b0, 1'b1, 1, CMD_ROTATE, 4'd3, RSSI_FLOOR, MODE_SWEEP);
    add_row(RSSI_FLOOR, 1'b1, 1'b1, 1, CMD_ROTATE, 4'd4, RSSI_FLOOR, MODE_SWEEP);
    add_row(8'sd0,      1'b1, 1'b1, 1, CMD_ROTATE, 4'd5, 8'sd0,      MODE_SWEEP);
    add_row(8'sd127,    1'b1, 1'b1, 1, CMD_ROTATE, 4'd6, 8'sd127,    MODE_SWEEP);
    add_row(-8'sd1,     1'b1, 1'b0, 0, CMD_ROTATE, 4'd0, 8'sd0,      MODE_SWEEP);
    // empty marker closing a scan keeps the peak seen so far
    add_row(8'sd3,      1'b0, 1'b1, 1, CMD_ROTATE, 4'd7, -8'sd1,     MODE_SWEEP);
    add_row(-8'sd90,    1'b1, 1'b1, 1, CMD_ROTATE, 4'd8, -8'sd90,    MODE_SWEEP);
    add_row(-8'sd80,    1'b1, 1'b1, 0, CMD_ROTATE, 4'd0, 8'sd0,      MODE_SWEEP);
    add_row(8'sd100,    1'b1, 1'b1, 0, CMD_ROTATE, 4'd0, 8'sd0,      MODE_SWEEP);
    add_row(8'sd126,    1'b1, 1'b1, 0, CMD_ROTATE, 4'd0, 8'sd0,      MODE_SWEEP);
    add_row(-8'sd5,     1'b1, 1'b1, 0, CMD_ROTATE, 4'd0, 8'sd0,      MODE_SWEEP);
    add_row(8'sd64,     1'b1, 1'b1, 0, CMD_ROTATE, 4'd0, 8'sd0,      MODE_SWEEP);
    // hold at reference 127, drop 6: 121 holds, 120 restarts the sweep
    add_row(8'sd121,    1'b1, 1'b1, 1, CMD_HOLD,   4'd1, 8'sd121,    MODE_HOLD);
    add_row(8'sd120,    1'b1, 1'b1, 1, CMD_ROTATE, 4'd1, 8'sd120,    MODE_SWEEP);
    // all-empty sweep ends on position 1
    for (int k = 0; k < NUM_POS; k++) begin
      add_row(8'($urandom), 1'b0, 1'b1, k == 0, CMD_ROTATE, 4'd2, RSSI_FLOOR, MODE_SWEEP);
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    apb_check_drop();

    foreach (directed_rows[i]) begin
      apply_sample(directed_rows[i].rssi, directed_rows[i].present, directed_rows[i].eos,
                   directed_rows[i].typed, directed_rows[i].cmd);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      // drain, let the block settle, then reprogram
      sample_if.valid <= 1'b0;
      while (expected_cmds.size() != 0) @(posedge clk_i);
      repeat (30) @(posedge clk_i);
      wdata = $urandom;
      case (ph)
        0: wdata[6:0] = 7'd0;
        1: wdata[6:0] = 7'd127;
        3: wdata[6:0] = 7'd1;
        5: wdata[6:0] = DROP_RESET;
        default: wdata[6:0] = 7'($urandom);
      endcase
      if (ph == 3) apb_write(REG_UNUSED, $urandom);
      apb_write(REG_HOLD_DROP, wdata);
      model_drop = wdata[6:0];
      apb_check_drop();

      case (ph % 4)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 49; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 49; end
        default: begin src_idle_pct = 37; snk_stall_pct = 37; end
      endcase

      sent = 0;
      while (sent < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
          // noise: unrelated flags and values
          apply_sample(8'($urandom), 1'($urandom), 1'($urandom), 0, '0);
          sent++;
        end else begin
          len = $urandom_range(1, 4);
          blank = ($urandom_range(0, 9) == 0);
          for (int j = 0; j < len; j++) begin
            present = !blank && ($urandom_range(0, 9) != 0);
            // in hold, stay near the reference so both hold and drop occur
            if (model_mode == MODE_HOLD && $urandom_range(0, 4) != 0) begin
              rssi = sat8(int'(model_hold_ref) + 2 -
                          int'($urandom_range(0, int'(model_drop) + 4)));
            end else begin
              rssi = 8'($urandom);
            end
            apply_sample(rssi, present, j == len - 1, 0, '0);
            sent++;
          end
        end
      end
    end

    sample_if.valid <= 1'b0;
    for (int k = 0; k < 20000 && expected_cmds.size() != 0; k++) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (expected_cmds.size() != 0) begin
      flag_error($sformatf("%0d commands never arrived", expected_cmds.size()));
    end
    if (n_errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
